@@ src/assert_macros.svh @@
// Assertion macros, included by the list's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/sclv_pkg.sv @@
// Types and codes for the sorted counted value list.
package sclv_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int unsigned TOTAL_BITS = 5;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [TOTAL_BITS-1:0] entry_total;
    logic                  status;
  } out_item_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               ins_new;  // place a new value (not found, not full)
    logic               ins_inc;  // bump the count of the matching cell
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

@@ src/sclv_cell.sv @@
// One cell of the sorted list: holds a value, its count and a valid flag.
module sclv_cell #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sclv_pkg::cell_ctl_t     ctl_i,
  input  logic signed [31:0]      left_value_i,
  input  logic [COUNT_BITS-1:0]   left_count_i,
  input  logic                    left_valid_i,
  input  logic                    left_gt_i,
  output logic signed [31:0]      value_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic                    valid_o,
  output logic                    gt_o,
  output logic                    match_o
);
  import sclv_pkg::*;

  logic signed [31:0]    value_q, value_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  valid_q, valid_d;

  // Empty cells count as larger, so the insert point is the first "gt" cell.
  assign gt_o    = !valid_q || (value_q > ctl_i.value);
  assign match_o = valid_q && (value_q == ctl_i.value);

  always_comb begin
    value_d = value_q;
    count_d = count_q;
    valid_d = valid_q;
    if (ctl_i.ins_new) begin
      if (left_gt_i) begin
        value_d = left_value_i;
        count_d = left_count_i;
        valid_d = left_valid_i;
      end else if (gt_o) begin
        value_d = ctl_i.value;
        count_d = COUNT_BITS'(1);
        valid_d = 1'b1;
      end
    end else if (ctl_i.ins_inc && match_o && (count_q != '1)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    count_q <= count_d;
  end

  assign value_o = value_q;
  assign count_o = count_q;
  assign valid_o = valid_q;

endmodule

@@ src/sorted_counted_value_list.sv @@
// Sorted counted value list: a row of compare-and-shift cells.
// The result is registered as the item is accepted.
// Throughput: 1 item per cycle while the output is taken; one cell-row compare plus a match OR per item.
// The output register frees as the result is taken, so input and output overlap.
// Reset (async, active low) empties the list at once; no clearing pass.
module sorted_counted_value_list #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sclv_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sclv_pkg::out_item_t  out_item_o
);
  import sclv_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned UW = $clog2(CAPACITY + 1);

  logic signed [31:0]    cell_value [CAPACITY];
  logic [COUNT_BITS-1:0] cell_count [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   cell_gt;
  logic [CAPACITY-1:0]   cell_match;

  cell_ctl_t   ctl;
  logic        in_fire;
  logic        is_insert;
  logic        found;
  logic        full;
  logic [UW-1:0]   used_q, used_d;
  logic [UW+TOTAL_BITS-1:0] used_wide;
  out_item_t   out_q, out_d;
  logic        out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_insert  = (in_item_i.cmd == CMD_INSERT);
  assign found      = |cell_match;
  assign full       = (used_q == UW'(CAPACITY));

  assign ctl.value   = in_item_i.value;
  assign ctl.ins_new = in_fire && is_insert && !found && !full;
  assign ctl.ins_inc = in_fire && is_insert && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      sclv_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .left_value_i ('0),
        .left_count_i ('0),
        .left_valid_i (1'b0),
        .left_gt_i    (1'b0),
        .value_o      (cell_value[i]),
        .count_o      (cell_count[i]),
        .valid_o      (cell_valid[i]),
        .gt_o         (cell_gt[i]),
        .match_o      (cell_match[i])
      );
    end else begin : g_body
      sclv_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .left_value_i (cell_value[i-1]),
        .left_count_i (cell_count[i-1]),
        .left_valid_i (cell_valid[i-1]),
        .left_gt_i    (cell_gt[i-1]),
        .value_o      (cell_value[i]),
        .count_o      (cell_count[i]),
        .valid_o      (cell_valid[i]),
        .gt_o         (cell_gt[i]),
        .match_o      (cell_match[i])
      );
    end
  end

  assign used_d    = ctl.ins_new ? (used_q + UW'(1)) : used_q;
  assign used_wide = {{TOTAL_BITS{1'b0}}, used_d};

  always_comb begin
    out_d.found       = found;
    out_d.entry_total = used_wide[TOTAL_BITS-1:0];
    out_d.status      = (is_insert && !found && full) ? STATUS_FULL : STATUS_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        used_q <= used_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Occupied cells form a prefix whose length is the entry count.
  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= UW'(CAPACITY))
  `ASSERT_ALWAYS(a_valid_count, clk_i, rst_ni, $countones(cell_valid) == 32'(used_q))
  `ASSERT_ALWAYS(a_single_match, clk_i, rst_ni, $onehot0(cell_match))
  `ASSERT_IMPL(a_full_not_found, clk_i, rst_ni, out_valid_q, !(out_q.status && out_q.found))
  `ASSERT_NEXT(a_new_grows, clk_i, rst_ni, ctl.ins_new, used_q == $past(used_q) + UW'(1))

endmodule
